// ----- src/swc_pkg.sv -----
// ----------------------------------------------------------------------------
// swc_pkg: shared types and constants for the segment window clipper
// Coordinate and register codes, the table of the eight clip checks, and the
// flow word that travels beside each segment down the cell chain.
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int CoordBits = 32;
  localparam int IndexBits = 4;
  localparam int NumChecks = 8;

  typedef enum logic [1:0] {
    COORD_SX,
    COORD_SY,
    COORD_EX,
    COORD_EY
  } coord_e;

  typedef enum logic [1:0] {
    REG_WEST,
    REG_EAST,
    REG_SOUTH,
    REG_NORTH
  } reg_e;

  typedef struct packed {
    coord_e own;
    coord_e base;
    coord_e far_own;
    coord_e far_base;
    reg_e   edge_sel;
    logic   upper;
  } check_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } flow_t;

  // Fixed order: start x, end x, start y, end y; lower edge before upper edge.
  function automatic check_t check_spec(input logic [2:0] k);
    check_t c;
    case (k)
      3'd0: c = '{COORD_SX, COORD_SY, COORD_EX, COORD_EY, REG_WEST,  1'b0};
      3'd1: c = '{COORD_SX, COORD_SY, COORD_EX, COORD_EY, REG_EAST,  1'b1};
      3'd2: c = '{COORD_EX, COORD_EY, COORD_SX, COORD_SY, REG_WEST,  1'b0};
      3'd3: c = '{COORD_EX, COORD_EY, COORD_SX, COORD_SY, REG_EAST,  1'b1};
      3'd4: c = '{COORD_SY, COORD_SX, COORD_EY, COORD_EX, REG_SOUTH, 1'b0};
      3'd5: c = '{COORD_SY, COORD_SX, COORD_EY, COORD_EX, REG_NORTH, 1'b1};
      3'd6: c = '{COORD_EY, COORD_EX, COORD_SY, COORD_SX, REG_SOUTH, 1'b0};
      3'd7: c = '{COORD_EY, COORD_EX, COORD_SY, COORD_SX, REG_NORTH, 1'b1};
      default: c = '{COORD_SX, COORD_SY, COORD_EX, COORD_EY, REG_WEST, 1'b0};
    endcase
    return c;
  endfunction

endpackage

// ----- src/swc_div_cell.sv -----
// ----------------------------------------------------------------------------
// swc_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// where it fits, and hands remainder, quotient and side data to the next cell.
// ----------------------------------------------------------------------------
module swc_div_cell #(
  parameter int W        = swc_pkg::CoordBits,
  parameter int SideBits = 4 * swc_pkg::CoordBits + 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  swc_pkg::flow_t      in_flow,
  input  logic [SideBits-1:0] in_side,
  input  logic [W:0]          in_rem,
  input  logic [W:0]          in_low,
  input  logic [W:0]          in_den,
  input  logic [W:0]          in_quo,
  output swc_pkg::flow_t      out_flow,
  output logic [SideBits-1:0] out_side,
  output logic [W:0]          out_rem,
  output logic [W:0]          out_low,
  output logic [W:0]          out_den,
  output logic [W:0]          out_quo
);

  logic [W+1:0] trial;
  logic         take;
  logic [W+1:0] rem_next;

  assign trial    = {in_rem, in_low[W]};
  assign take     = trial >= {1'b0, in_den};
  assign rem_next = take ? trial - {1'b0, in_den} : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_flow <= '0;
    end else if (advance) begin
      out_flow <= in_flow;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_side <= in_side;
      out_rem  <= rem_next[W:0];
      out_low  <= {in_low[W-1:0], 1'b0};
      out_den  <= in_den;
      out_quo  <= {in_quo[W-1:0], take};
    end
  end

endmodule

// ----- src/swc_clip_stage.sv -----
// ----------------------------------------------------------------------------
// swc_clip_stage: one clip check of the window
// Compare and clamp, form the three distances, multiply, then run a row of
// division cells and finish with a saturating add onto the moved coordinate.
// ----------------------------------------------------------------------------
module swc_clip_stage #(
  parameter int         W     = swc_pkg::CoordBits,
  parameter logic [2:0] CHECK = 3'd0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [3:0][W-1:0]     edges,
  input  swc_pkg::flow_t        in_flow,
  input  logic [3:0][W-1:0]     in_pts,
  output swc_pkg::flow_t        out_flow,
  output logic [3:0][W-1:0]     out_pts
);

  localparam swc_pkg::check_t Spec = swc_pkg::check_spec(CHECK);
  localparam int MW       = W + 1;
  localparam int PW       = 2 * MW;
  localparam int SideBits = 4 * W + 3;

  function automatic logic [W:0] mag(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    return d[W] ? (~d + 1'b1) : d;
  endfunction

  // setup: compare, clamp, distances
  logic signed [W-1:0] own_c, base_c, far_own_c, far_base_c, edge_c;
  logic                fire, move_c, neg_c;
  logic [3:0][W-1:0]   pts_c;

  assign own_c      = in_pts[Spec.own];
  assign base_c     = in_pts[Spec.base];
  assign far_own_c  = in_pts[Spec.far_own];
  assign far_base_c = in_pts[Spec.far_base];
  assign edge_c     = edges[Spec.edge_sel];

  assign fire   = Spec.upper ? (own_c > edge_c) : (own_c < edge_c);
  assign move_c = fire && (own_c != far_own_c);
  assign neg_c  = (edge_c < own_c) ^ (far_base_c < base_c) ^ (far_own_c < own_c);

  always_comb begin
    pts_c = in_pts;
    if (fire) begin
      pts_c[Spec.own] = edge_c;
    end
  end

  swc_pkg::flow_t    a_flow, b_flow, c_flow, f_flow;
  logic [3:0][W-1:0] a_pts, b_pts, c_pts, f_pts;
  logic              a_move, a_neg, b_move, b_neg, c_move, c_neg, c_ovf;
  logic [W:0]        a_mag0, a_mag1, a_den, b_den, c_den, c_rem, c_low;
  logic [PW-1:0]     b_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_flow <= '0;
      b_flow <= '0;
      c_flow <= '0;
    end else if (advance) begin
      a_flow <= '{valid: in_flow.valid, hit: in_flow.hit | fire};
      b_flow <= a_flow;
      c_flow <= b_flow;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_pts  <= pts_c;
      a_move <= move_c;
      a_neg  <= neg_c;
      a_mag0 <= mag(edge_c, own_c);
      a_mag1 <= mag(far_base_c, base_c);
      a_den  <= mag(far_own_c, own_c);
      b_pts  <= a_pts;
      b_move <= a_move;
      b_neg  <= a_neg;
      b_prod <= a_mag0 * a_mag1;
      b_den  <= a_den;
      c_pts  <= b_pts;
      c_move <= b_move;
      c_neg  <= b_neg;
      c_ovf  <= b_prod[PW-1:MW] >= b_den;
      c_rem  <= b_prod[PW-1:MW];
      c_low  <= b_prod[MW-1:0];
      c_den  <= b_den;
    end
  end

  // row of division cells, one quotient bit each
  swc_pkg::flow_t      ch_flow [0:MW];
  logic [SideBits-1:0] ch_side [0:MW];
  logic [W:0]          ch_rem  [0:MW];
  logic [W:0]          ch_low  [0:MW];
  logic [W:0]          ch_den  [0:MW];
  logic [W:0]          ch_quo  [0:MW];

  assign ch_flow[0] = c_flow;
  assign ch_side[0] = {c_pts, c_move, c_neg, c_ovf};
  assign ch_rem[0]  = c_rem;
  assign ch_low[0]  = c_low;
  assign ch_den[0]  = c_den;
  assign ch_quo[0]  = '0;

  for (genvar i = 0; i < MW; i++) begin : g_cell
    swc_div_cell #(.W(W), .SideBits(SideBits)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .in_flow  (ch_flow[i]),
      .in_side  (ch_side[i]),
      .in_rem   (ch_rem[i]),
      .in_low   (ch_low[i]),
      .in_den   (ch_den[i]),
      .in_quo   (ch_quo[i]),
      .out_flow (ch_flow[i+1]),
      .out_side (ch_side[i+1]),
      .out_rem  (ch_rem[i+1]),
      .out_low  (ch_low[i+1]),
      .out_den  (ch_den[i+1]),
      .out_quo  (ch_quo[i+1])
    );
  end

  // finish: saturating add of the quotient onto the base coordinate
  logic [3:0][W-1:0]   d_pts;
  logic                d_move, d_neg, d_ovf;
  logic signed [W+2:0] base_x, quo_x, sum, max_x, min_x;
  logic                sat_hi, sat_lo;
  logic [W-1:0]        moved;
  logic [3:0][W-1:0]   pts_f;

  assign {d_pts, d_move, d_neg, d_ovf} = ch_side[MW];
  assign base_x = {{3{d_pts[Spec.base][W-1]}}, d_pts[Spec.base]};
  assign quo_x  = {2'b00, ch_quo[MW]};
  assign sum    = d_neg ? base_x - quo_x : base_x + quo_x;
  assign max_x  = {4'b0000, {(W-1){1'b1}}};
  assign min_x  = {4'b1111, {(W-1){1'b0}}};
  assign sat_hi = !d_neg && (d_ovf || sum > max_x);
  assign sat_lo = d_neg && (d_ovf || sum < min_x);
  assign moved  = sat_hi ? max_x[W-1:0] : (sat_lo ? min_x[W-1:0] : sum[W-1:0]);

  always_comb begin
    pts_f = d_pts;
    if (d_move) begin
      pts_f[Spec.base] = moved;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_flow <= '0;
    end else if (advance) begin
      f_flow <= ch_flow[MW];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f_pts <= pts_f;
    end
  end

  assign out_flow = f_flow;
  assign out_pts  = f_pts;

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    a_flow.valid && a_move |-> a_den != '0)
    else $error("move set with zero divisor");

  a_move_needs_hit: assert property (@(posedge clk) disable iff (rst)
    a_flow.valid && !a_flow.hit |-> !a_move)
    else $error("move without a fired check");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ch_flow[MW].valid && d_move && !d_ovf |-> ch_rem[MW] < ch_den[MW])
    else $error("remainder not below divisor");

endmodule

// ----- src/segment_window_clipper.sv -----
// ----------------------------------------------------------------------------
// segment_window_clipper: clips a segment against a rectangular window
// Eight clip stages in a row, each a compare/clamp cell, a multiplier and a
// row of division cells; coordinates are signed fixed point (Q24.8 default).
// ----------------------------------------------------------------------------
//
//   channel  handshake                    payload
//   input    in_valid / in_ready          start_x start_y end_x end_y
//   output   out_valid / out_ready        clipped_start_x .. clipped_end_y,
//                                         was_clipped
//   config   write_enable                 reg_index, write_data
//
// One segment enters per cycle while the output is not held. Each stage
// registers setup, multiply, divide entry, COORD_BITS + 1 divide cells and
// the finish add; the output register follows the last stage.
// The whole chain holds while a result waits at the output and out_ready is low.
// Reset clears the valid bits and the window registers to zero.
//
module segment_window_clipper #(
  parameter int COORD_BITS = swc_pkg::CoordBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COORD_BITS-1:0]         start_x,
  input  logic [COORD_BITS-1:0]         start_y,
  input  logic [COORD_BITS-1:0]         end_x,
  input  logic [COORD_BITS-1:0]         end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_BITS-1:0]         clipped_start_x,
  output logic [COORD_BITS-1:0]         clipped_start_y,
  output logic [COORD_BITS-1:0]         clipped_end_x,
  output logic [COORD_BITS-1:0]         clipped_end_y,
  output logic                          was_clipped,
  input  logic                          write_enable,
  input  logic [swc_pkg::IndexBits-1:0] reg_index,
  input  logic [COORD_BITS-1:0]         write_data
);

  localparam int N = swc_pkg::NumChecks;

  logic [3:0][COORD_BITS-1:0] edges;
  logic                       advance;

  // indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      edges <= '0;
    end else if (write_enable && reg_index[swc_pkg::IndexBits-1:2] == '0) begin
      edges[reg_index[1:0]] <= write_data;
    end
  end

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  swc_pkg::flow_t             st_flow [0:N];
  logic [3:0][COORD_BITS-1:0] st_pts  [0:N];

  assign st_flow[0] = '{valid: in_valid && in_ready, hit: 1'b0};
  assign st_pts[0]  = {end_y, end_x, start_y, start_x};

  for (genvar k = 0; k < N; k++) begin : g_stage
    swc_clip_stage #(.W(COORD_BITS), .CHECK(3'(k))) u_stage (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .edges    (edges),
      .in_flow  (st_flow[k]),
      .in_pts   (st_pts[k]),
      .out_flow (st_flow[k+1]),
      .out_pts  (st_pts[k+1])
    );
  end

  logic [3:0][COORD_BITS-1:0] res_pts;
  logic                       res_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= st_flow[N].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_pts <= st_pts[N];
      res_hit <= st_flow[N].hit;
    end
  end

  assign clipped_start_x = res_pts[swc_pkg::COORD_SX];
  assign clipped_start_y = res_pts[swc_pkg::COORD_SY];
  assign clipped_end_x   = res_pts[swc_pkg::COORD_EX];
  assign clipped_end_y   = res_pts[swc_pkg::COORD_EY];
  assign was_clipped     = res_hit;

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_pts) && $stable(res_hit))
    else $error("result register changed while stalled");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !st_flow[0].valid)
    else $error("segment taken while chain held");

endmodule

// ----- dv/segment_window_clipper_tb.sv -----
// ----------------------------------------------------------------------------
// segment_window_clipper_tb: self-checking bench for the segment window clipper
// Streams segments through the clip pipeline under random idling on both
// sides, predicts each clipped segment in the bench and compares every word
// that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module segment_window_clipper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = swc_pkg::CoordBits;
  localparam int IW = swc_pkg::IndexBits;
  localparam int Latency = 8 * (W + 5) + 1;
  localparam int WatchdogLimit = 20 * Latency + 2000;
  localparam int StallCycles = Latency + 200;
  localparam logic signed [W-1:0] CoordMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CoordMin = {1'b1, {(W-1){1'b0}}};

  typedef struct {
    logic [W-1:0] sx, sy, ex, ey;
  } segment_t;

  typedef struct {
    logic [W-1:0] sx, sy, ex, ey;
    logic hit;
  } clipped_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [W-1:0] start_x, start_y, end_x, end_y;
  logic [W-1:0] clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y;
  logic was_clipped;
  logic write_enable;
  logic [IW-1:0] reg_index;
  logic [W-1:0] write_data;

  logic signed [W-1:0] win_west, win_east, win_south, win_north;

  segment_t segment_queue[$];
  clipped_t clipped_queue[$];
  int errors;
  int watchdog;
  int stall_hold;
  int in_gap, out_gap;
  bit idle_off;
  bit stall_req;
  bit stall_done;

  segment_window_clipper u_top (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // other + trunc((edge - own) * (far_other - other) / (far_own - own)), saturated
  function automatic logic signed [W-1:0] slide_point(
      input logic signed [W-1:0] base, input logic signed [W-1:0] edge_v,
      input logic signed [W-1:0] own, input logic signed [W-1:0] far_own,
      input logic signed [W-1:0] far_base);
    logic signed [2*W+3:0] num, quo, sum;
    num = ($signed({{(W+4){edge_v[W-1]}}, edge_v}) - own) *
          ($signed({{(W+4){far_base[W-1]}}, far_base}) - base);
    quo = num / ($signed({{(W+4){far_own[W-1]}}, far_own}) - own);
    sum = quo + base;
    if (sum > CoordMax) return CoordMax;
    if (sum < CoordMin) return CoordMin;
    return sum[W-1:0];
  endfunction

  function automatic clipped_t clip_segment(input segment_t s);
    logic signed [W-1:0] sx, sy, ex, ey;
    clipped_t r;
    sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey;
    r.hit = 1'b0;
    if (sx < win_west) begin
      if (ex != sx) sy = slide_point(sy, win_west, sx, ex, ey);
      sx = win_west; r.hit = 1'b1;
    end
    if (sx > win_east) begin
      if (ex != sx) sy = slide_point(sy, win_east, sx, ex, ey);
      sx = win_east; r.hit = 1'b1;
    end
    if (ex < win_west) begin
      if (ex != sx) ey = slide_point(ey, win_west, ex, sx, sy);
      ex = win_west; r.hit = 1'b1;
    end
    if (ex > win_east) begin
      if (ex != sx) ey = slide_point(ey, win_east, ex, sx, sy);
      ex = win_east; r.hit = 1'b1;
    end
    if (sy < win_south) begin
      if (ey != sy) sx = slide_point(sx, win_south, sy, ey, ex);
      sy = win_south; r.hit = 1'b1;
    end
    if (sy > win_north) begin
      if (ey != sy) sx = slide_point(sx, win_north, sy, ey, ex);
      sy = win_north; r.hit = 1'b1;
    end
    if (ey < win_south) begin
      if (ey != sy) ex = slide_point(ex, win_south, ey, sy, sx);
      ey = win_south; r.hit = 1'b1;
    end
    if (ey > win_north) begin
      if (ey != sy) ex = slide_point(ex, win_north, ey, sy, sx);
      ey = win_north; r.hit = 1'b1;
    end
    r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
    return r;
  endfunction

  // Driver: hold the word until accepted, then advance or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
      start_x <= '0;
      start_y <= '0;
      end_x <= '0;
      end_y <= '0;
    end else begin
      if (in_valid && in_ready) begin
        clipped_queue.push_back(clip_segment(segment_queue.pop_front()));
      end
      if (!in_valid || in_ready) begin
        if (in_valid && in_ready && !idle_off && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else begin
          if (segment_queue.size() > 0) begin
            in_valid <= 1'b1;
            start_x <= segment_queue[0].sx;
            start_y <= segment_queue[0].sy;
            end_x <= segment_queue[0].ex;
            end_y <= segment_queue[0].ey;
          end else begin
            in_valid <= 1'b0;
          end
        end
      end
    end
  end

  // Monitor: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap <= 0;
      stall_hold <= 0;
      stall_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (clipped_queue.size() == 0) begin
          $display("%0t: unexpected word sx=%h sy=%h ex=%h ey=%h hit=%b", $time,
                   clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y,
                   was_clipped);
          errors++;
        end else begin
          clipped_t e;
          e = clipped_queue.pop_front();
          if (e.sx !== clipped_start_x)
            $display("%0t: start_x expected %h got %h", $time, e.sx, clipped_start_x);
          if (e.sy !== clipped_start_y)
            $display("%0t: start_y expected %h got %h", $time, e.sy, clipped_start_y);
          if (e.ex !== clipped_end_x)
            $display("%0t: end_x expected %h got %h", $time, e.ex, clipped_end_x);
          if (e.ey !== clipped_end_y)
            $display("%0t: end_y expected %h got %h", $time, e.ey, clipped_end_y);
          if (e.hit !== was_clipped)
            $display("%0t: was_clipped expected %b got %b", $time, e.hit, was_clipped);
          if (e.sx !== clipped_start_x || e.sy !== clipped_start_y ||
              e.ex !== clipped_end_x || e.ey !== clipped_end_y || e.hit !== was_clipped)
            errors++;
        end
      end
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        out_ready <= 1'b0;
      end else if (stall_req && !stall_done && out_valid) begin
        // hold off once the first word shows up, so the chain backs up
        stall_hold <= StallCycles - 1;
        stall_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 6) == 0) begin
        out_gap <= $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      watchdog <= 0;
    end else if (watchdog >= WatchdogLimit) begin
      $display("segment_window_clipper: mismatch");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  function automatic logic [W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return CoordMax - $urandom_range(0, 3);
      1: return CoordMin + $urandom_range(0, 3);
      2: return $urandom();
      default: return $signed($urandom_range(0, 8000)) - 4000;
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t s;
    s.sx = rand_coord(); s.sy = rand_coord();
    s.ex = ($urandom_range(0, 9) == 0) ? s.sx : rand_coord();
    s.ey = ($urandom_range(0, 9) == 0) ? s.sy : rand_coord();
    return s;
  endfunction

  task automatic add_segment(input logic [W-1:0] sx, sy, ex, ey);
    segment_t s;
    s.sx = sx; s.sy = sy; s.ex = ex; s.ey = ey;
    segment_queue.push_back(s);
  endtask

  // Write one window edge while the pipeline is empty.
  task automatic write_edge(input swc_pkg::reg_e idx, input logic [W-1:0] val);
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= IW'(idx);
    write_data <= val;
    @(posedge clk);
    write_enable <= 1'b0;
    case (idx)
      swc_pkg::REG_WEST: win_west = val;
      swc_pkg::REG_EAST: win_east = val;
      swc_pkg::REG_SOUTH: win_south = val;
      default: win_north = val;
    endcase
  endtask

  task automatic set_window(input logic [W-1:0] w, e, s, n);
    write_edge(swc_pkg::REG_WEST, w);
    write_edge(swc_pkg::REG_EAST, e);
    write_edge(swc_pkg::REG_SOUTH, s);
    write_edge(swc_pkg::REG_NORTH, n);
  endtask

  task automatic drain();
    wait (segment_queue.size() == 0 && clipped_queue.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    write_enable = 1'b0;
    reg_index = '0;
    write_data = '0;
    idle_off = 1'b0;
    stall_req = 1'b0;
    win_west = '0; win_east = '0; win_south = '0; win_north = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // index beyond the four edges: ignored
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= IW'(swc_pkg::REG_NORTH) + IW'(5);
    write_data <= 32'h1234;
    @(posedge clk);
    write_enable <= 1'b0;

    // Directed: zero window after reset, then a normal window
    add_segment(32'sd100, -32'sd50, -32'sd100, 32'sd50);
    add_segment(CoordMax, CoordMin, CoordMin, CoordMax);
    drain();
    set_window(-32'sd2560, 32'sd2560, -32'sd1280, 32'sd1280);
    add_segment(32'sd0, 32'sd0, 32'sd256, 32'sd256);             // inside
    add_segment(-32'sd5000, 32'sd0, 32'sd5000, 32'sd300);        // crosses both x
    add_segment(32'sd100, -32'sd4000, 32'sd100, 32'sd4000);      // shared x
    add_segment(-32'sd4000, 32'sd7, 32'sd4000, 32'sd7);          // shared y
    add_segment(32'sd9000, 32'sd9000, 32'sd9500, 32'sd9900);     // wholly outside
    add_segment(CoordMin, CoordMax, CoordMax, CoordMin);
    add_segment(CoordMin, 32'sd0, CoordMin + 1, CoordMax);       // move overflow
    add_segment(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0);
    drain();
    // inverted window and extreme edges
    set_window(32'sd1000, -32'sd1000, 32'sd500, -32'sd500);
    add_segment(32'sd0, 32'sd0, 32'sd10, 32'sd20);
    add_segment(-32'sd3000, 32'sd3000, 32'sd3000, -32'sd3000);
    drain();
    set_window(CoordMin, CoordMax, CoordMin, CoordMax);
    add_segment(CoordMin, CoordMin, CoordMax, CoordMax);
    add_segment(32'sd1, -32'sd1, 32'sd2, -32'sd2);
    drain();
    set_window(CoordMax, CoordMin, CoordMax, CoordMin);
    add_segment(CoordMin, CoordMax, 32'sd0, 32'sd1);
    add_segment(32'sd3, 32'sd3, 32'sd3, 32'sd3);
    drain();

    // Random phases with fresh windows
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) set_window(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      else set_window(-$urandom_range(0, 3000), $urandom_range(0, 3000),
                      -$urandom_range(0, 3000), $urandom_range(0, 3000));
      // long batch outlasts the latency, so the held output stalls the input
      if (ph == 2) stall_req = 1'b1;
      if (ph == 5) idle_off = 1'b1;
      for (int i = 0; i < ((ph == 2) ? 320 : 64); i++)
        segment_queue.push_back(rand_segment());
      drain();  // sender pauses until every result is back
    end

    repeat (Latency + 20) @(posedge clk);
    if (errors == 0) $display("segment_window_clipper: match");
    else $display("segment_window_clipper: mismatch");
    $finish;
  end
endmodule
